>>> hw/rtl/drs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package drs_pkg;

   localparam int VALUE_W      = 31;
   localparam int DIGITS       = 10;
   localparam int BCD_W        = 4 * DIGITS;
   localparam int CAPACITY_DEF = 64;

   // one store entry: binary value plus its decimal digits
   typedef struct packed {
      logic [BCD_W-1:0]   bcd;
      logic [VALUE_W-1:0] value;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             done;
      logic [BCD_W-1:0] bcd;
   } bcd_result_type;

   // number of significant decimal digits (zero has none)
   function automatic logic [3:0] digit_count(input logic [BCD_W-1:0] bcd);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd[4*i +: 4] != 4'd0) begin
            n = 4'(i + 1);
         end
      end
      return n;
   endfunction

   // decimal digit k, zero beyond the top digit
   function automatic logic [3:0] bcd_digit(input logic [BCD_W-1:0] bcd,
                                            input logic [3:0]       k);
      logic [3:0] d;
      d = 4'd0;
      for (int i = 0; i < DIGITS; i++) begin
         if (k == 4'(i)) begin
            d = bcd[4*i +: 4];
         end
      end
      return d;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/decimal_lsd_radix_sort.sv
`timescale 1ns / 1ps
`default_nettype none

// Decimal LSD radix sorter.
// req channel: one non-negative value per request, req_tlast on the final
//   value of a set. Up to CAPACITY values are kept; further ones are dropped
//   and every result of that set then carries rsp_tuser = 1.
// rsp channel: the stored values in ascending order, rsp_tlast on the last.
// Loading: each stored request runs through the 31-step binary to BCD
//   converter (one add-3/shift step a cycle); a dropped request skips it.
// Sort, after the last request: one counting pass per decimal digit of the
//   widest value (bucket clear, count sweep, ten-step prefix sum, scatter
//   sweep into the other store; the two stores swap roles each pass).
//   All-zero sets skip the passes.
// Output: results are read one at a time through the store's single read port
//   (issue read, load result register); the result register holds its request
//   untouched while the receiver holds rsp_tready low.
// req_tready is high only while idle. Reset empties the set and returns the
//   block to idle at once; no clearing sweep is needed.
module decimal_lsd_radix_sort #(
   parameter int CAPACITY = drs_pkg::CAPACITY_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [30:0] value, [31] zero
   input  wire logic        req_tlast,   // is_last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // [30:0] sorted_value, [31] zero
   output logic             rsp_tlast,   // last_out
   output logic             rsp_tuser    // [0] overflowed
);

   import drs_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   // sequencer codes
   localparam logic [3:0] S_IDLE  = 4'd0;  // taking requests
   localparam logic [3:0] S_CONV  = 4'd1;  // BCD conversion running
   localparam logic [3:0] S_CLR   = 4'd2;  // clear buckets
   localparam logic [3:0] S_CNT   = 4'd3;  // count sweep
   localparam logic [3:0] S_PFX   = 4'd4;  // counts to start positions
   localparam logic [3:0] S_DST   = 4'd5;  // scatter sweep
   localparam logic [3:0] S_ORD   = 4'd6;  // issue output read
   localparam logic [3:0] S_OLD   = 4'd7;  // load result register
   localparam logic [3:0] S_OHOLD = 4'd8;  // wait for receiver

   logic [3:0]         state_ff, state_in;
   logic [CW-1:0]      item_count_ff, item_count_in;
   logic [3:0]         max_digits_ff, max_digits_in;
   logic               ovf_ff, ovf_in;
   logic               last_ff, last_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [3:0]         pass_ff, pass_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [3:0]         bidx_ff, bidx_in;
   logic [CW-1:0]      run_ff, run_in;
   logic [CW-1:0]      bucket_ff [DIGITS];
   logic [CW-1:0]      bucket_in [DIGITS];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   bcd_result_type     bcd_res;
   logic               conv_start;
   entry_type          rdata_a, rdata_b, rd_entry, wr_entry;
   logic               we_a, we_b;
   logic [AW-1:0]      waddr_a;
   logic [3:0]         digit, bk_idx, md_new;
   logic [CW-1:0]      bk_cur;
   logic               req_acc, room;

   drs_bcd u_bcd (
      .clock (clock),
      .reset (reset),
      .start (conv_start),
      .bin   (req_tdata[VALUE_W-1:0]),
      .res   (bcd_res)
   );

   // ping-pong stores: even passes read A and write B, odd passes the reverse
   drs_ram #(.DEPTH(CAPACITY), .WIDTH(ENTRY_W)) u_ram_a (
      .clock (clock),
      .we    (we_a),
      .waddr (waddr_a),
      .wdata (wr_entry),
      .raddr (ptr_ff[AW-1:0]),
      .rdata (rdata_a)
   );

   drs_ram #(.DEPTH(CAPACITY), .WIDTH(ENTRY_W)) u_ram_b (
      .clock (clock),
      .we    (we_b),
      .waddr (bk_cur[AW-1:0]),
      .wdata (wr_entry),
      .raddr (ptr_ff[AW-1:0]),
      .rdata (rdata_b)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign room       = (item_count_ff < CW'(CAPACITY));
   assign conv_start = req_acc && room;

   assign rd_entry = pass_ff[0] ? rdata_b : rdata_a;
   assign digit    = bcd_digit(rd_entry.bcd, pass_ff);
   assign md_new   = (digit_count(bcd_res.bcd) > max_digits_ff) ?
                     digit_count(bcd_res.bcd) : max_digits_ff;

   // single bucket read port: prefix step walks the buckets, sweeps use digit
   assign bk_idx = (state_ff == S_PFX) ? bidx_ff : digit;
   always_comb begin
      bk_cur = '0;
      for (int b = 0; b < DIGITS; b++) begin
         if (bk_idx == 4'(b)) begin
            bk_cur = bucket_ff[b];
         end
      end
   end

   // store writes: load into A, scatter into the store not being read
   always_comb begin
      we_a     = 1'b0;
      we_b     = 1'b0;
      waddr_a  = bk_cur[AW-1:0];
      wr_entry = rd_entry;
      if (state_ff == S_CONV) begin
         we_a         = bcd_res.done;
         waddr_a      = item_count_ff[AW-1:0];
         wr_entry.bcd = bcd_res.bcd;
         wr_entry.value = value_ff;
      end else if (state_ff == S_DST && rd_vld_ff) begin
         we_a = pass_ff[0];
         we_b = !pass_ff[0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      item_count_in = item_count_ff;
      max_digits_in = max_digits_ff;
      ovf_in        = ovf_ff;
      last_in       = last_ff;
      value_in      = value_ff;
      pass_in       = pass_ff;
      ptr_in        = ptr_ff;
      rd_vld_in     = 1'b0;
      bidx_in       = bidx_ff;
      run_in        = run_ff;
      bucket_in     = bucket_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               value_in = req_tdata[VALUE_W-1:0];
               last_in  = req_tlast;
               if (room) begin
                  state_in = S_CONV;
               end else begin
                  ovf_in = 1'b1;
                  if (req_tlast) begin
                     pass_in  = '0;
                     ptr_in   = '0;
                     state_in = (max_digits_ff == 4'd0) ? S_ORD : S_CLR;
                  end
               end
            end
         end
         S_CONV: begin
            if (bcd_res.done) begin
               item_count_in = item_count_ff + CW'(1);
               max_digits_in = md_new;
               if (last_ff) begin
                  pass_in  = '0;
                  ptr_in   = '0;
                  state_in = (md_new == 4'd0) ? S_ORD : S_CLR;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_CLR: begin
            for (int b = 0; b < DIGITS; b++) begin
               bucket_in[b] = '0;
            end
            ptr_in   = '0;
            state_in = S_CNT;
         end
         S_CNT, S_DST: begin
            if (ptr_ff < item_count_ff) begin
               ptr_in    = ptr_ff + CW'(1);
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               for (int b = 0; b < DIGITS; b++) begin
                  if (digit == 4'(b)) begin
                     bucket_in[b] = bucket_ff[b] + CW'(1);
                  end
               end
            end
            if (ptr_ff == item_count_ff && !rd_vld_ff) begin
               if (state_ff == S_CNT) begin
                  bidx_in  = '0;
                  run_in   = '0;
                  state_in = S_PFX;
               end else begin
                  pass_in = pass_ff + 4'd1;
                  ptr_in  = '0;
                  state_in = (pass_ff + 4'd1 == max_digits_ff) ? S_ORD : S_CLR;
               end
            end
         end
         S_PFX: begin
            for (int b = 0; b < DIGITS; b++) begin
               if (bidx_ff == 4'(b)) begin
                  bucket_in[b] = run_ff;
               end
            end
            run_in  = run_ff + bk_cur;
            bidx_in = bidx_ff + 4'd1;
            if (bidx_ff == 4'(DIGITS - 1)) begin
               ptr_in   = '0;
               state_in = S_DST;
            end
         end
         S_ORD: begin
            state_in = S_OLD;
         end
         S_OLD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = rd_entry.value;
            rsp_last_in  = (ptr_ff + CW'(1) == item_count_ff);
            rsp_ovf_in   = ovf_ff;
            state_in     = S_OHOLD;
         end
         S_OHOLD: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  item_count_in = '0;
                  max_digits_in = '0;
                  ovf_in        = 1'b0;
                  state_in      = S_IDLE;
               end else begin
                  ptr_in   = ptr_ff + CW'(1);
                  state_in = S_ORD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         item_count_ff <= '0;
         max_digits_ff <= '0;
         ovf_ff        <= 1'b0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         item_count_ff <= item_count_in;
         max_digits_ff <= max_digits_in;
         ovf_ff        <= ovf_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      value_ff    <= value_in;
      pass_ff     <= pass_in;
      ptr_ff      <= ptr_in;
      bidx_ff     <= bidx_in;
      run_ff      <= run_in;
      bucket_ff   <= bucket_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   // no requests taken while a result is on offer
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted while result pending");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      item_count_ff <= CW'(CAPACITY))
      else $error("item count beyond capacity");

   // scatter position always inside the stored set
   a_scatter_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DST && rd_vld_ff) |-> (bk_cur < item_count_ff))
      else $error("scatter position out of range");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=>
         (state_ff == S_IDLE && item_count_ff == '0 && !ovf_ff))
      else $error("set not cleared after final result");

endmodule

`default_nettype wire

>>> hw/rtl/drs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module drs_ram #(
   parameter int DEPTH = drs_pkg::CAPACITY_DEF,
   parameter int WIDTH = drs_pkg::ENTRY_W
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

>>> hw/rtl/drs_bcd.sv
`timescale 1ns / 1ps
`default_nettype none

// Iterative binary to BCD converter: one add-3 / shift step per cycle.
module drs_bcd (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [drs_pkg::VALUE_W-1:0]   bin,
   output drs_pkg::bcd_result_type            res
);

   import drs_pkg::*;

   localparam int CNT_W = $clog2(VALUE_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [BCD_W-1:0]   adj;

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                     : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         bin_in  = bin;
         bcd_in  = '0;
      end else if (busy_ff) begin
         {bcd_in, bin_in} = {adj[BCD_W-2:0], bin_ff, 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(VALUE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign res.done = done_ff;
   assign res.bcd  = bcd_ff;

endmodule

`default_nettype wire
